/* rtl/core/btr_pkg.sv */
// Shared types, constants and helpers of the bilinear texture resampler.
// Used by btr_div and the bilinear_texture_resampler top level.
`timescale 1ns / 1ps

package btr_pkg;

  localparam int CH_W          = 8;
  localparam int TEXEL_W       = 3 * CH_W;
  localparam int COORD_W       = 8;
  localparam int SIZE_W        = 9;
  localparam int PROD_W        = COORD_W + SIZE_W;
  localparam int DIM_W         = 13;
  localparam int MAX_DIM_DEF   = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_LOC,
    ST_READ,
    ST_WAIT,
    ST_LERP_A,
    ST_LERP_B,
    ST_FIN
  } state_t;

  // Clamp a size register into 1..max_dim.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] v_ext;
    v_ext = DIM_W'(v);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (v_ext > max_dim) begin
      return SIZE_W'(max_dim);
    end
    return v;
  endfunction

endpackage

/* rtl/core/bilinear_texture_resampler.sv */
// Top level of the bilinear texture resampler: texel memory, sequencer,
// lerp datapath and APB register file. Depends on btr_pkg and btr_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): each transfer is one item. action
//   ACT_WRITE stores the texel {red_in, green_in, blue_in} at (coord_x,
//   coord_y) and produces nothing; writes outside MAX_DIM are dropped.
//   ACT_SAMPLE names a destination pixel and produces one filtered RGB
//   transfer on the output channel (out_valid / out_stall).
//   A write is stored as it is accepted. The time a sample takes from accept to
//   out_valid, and so until the next item is taken, is set by the two
//   one-bit-per-cycle dividers (FRAC_BITS + 17 steps, run side by side) and by
//   the four texel reads that go one after another through the single memory
//   read port.
//   One item is in flight at a time; in_stall is high while a sample works.
//   The result sits in an output register, so a new item is accepted while
//   the receiver stalls; a finished sample then holds until that register
//   frees up.
//   Reset clears the sequencer and output valid and sets all four size
//   registers to 256. Texel memory is not cleared: write before sampling.
//   The user must write the size registers over APB only while the block is idle; the block does not enforce it.
module bilinear_texture_resampler import btr_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [CH_W-1:0]    red_in,
  input  logic [CH_W-1:0]    green_in,
  input  logic [CH_W-1:0]    blue_in,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    red_out,
  output logic [CH_W-1:0]    green_out,
  output logic [CH_W-1:0]    blue_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW     = $clog2(MAX_DIM);
  localparam int DEPTH  = 2 ** (2 * AW);
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int IP_W   = NUM_W - FRAC_BITS;
  localparam int PW     = CH_W + 2 + FRAC_BITS + 1;
  localparam logic [DIM_W-1:0] MAX_DIM_W = DIM_W'(MAX_DIM);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_RESET;
      src_height <= SIZE_RESET;
      dst_width  <= SIZE_RESET;
      dst_height <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SRC_WIDTH:  src_width  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SIZE_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[SIZE_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_DST_WIDTH:  prdata = 32'(dst_width);
      REG_DST_HEIGHT: prdata = 32'(dst_height);
      default:        prdata = '0;
    endcase
  end

  // Sizes as used by the datapath: zero reads as 1, oversize as MAX_DIM.
  assign sw = eff_size(src_width,  MAX_DIM_W);
  assign sh = eff_size(src_height, MAX_DIM_W);
  assign dw = eff_size(dst_width,  MAX_DIM_W);
  assign dh = eff_size(dst_height, MAX_DIM_W);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t state, state_next;
  logic   in_xfer, out_xfer, out_free;
  logic   div_start, mem_re, out_load;
  logic   done_x, done_y;
  logic [1:0] rd_cnt;

  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid & ~out_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && action == ACT_SAMPLE) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (done_x) begin
          state_next = ST_LOC;
        end
      end
      ST_LOC: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        mem_re = 1'b1;
        if (rd_cnt == 2'd3) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_LERP_A;
      end
      ST_LERP_A: begin
        state_next = ST_LERP_B;
      end
      ST_LERP_B: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Source position: (coord * src * 2^FRAC_BITS) / dst on both axes
  // ---------------------------------------------------------------------
  logic [COORD_W-1:0] cx, cy;
  logic [NUM_W-1:0]   num_x, num_y, quot_x, quot_y;
  logic [PROD_W-1:0]  prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cx <= coord_x;
      cy <= coord_y;
    end
  end

  assign prod_x = PROD_W'(cx) * PROD_W'(sw);
  assign prod_y = PROD_W'(cy) * PROD_W'(sh);
  assign num_x  = {prod_x, {FRAC_BITS{1'b0}}};
  assign num_y  = {prod_y, {FRAC_BITS{1'b0}}};

  btr_div #(.NUM_W(NUM_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (dw),
    .done  (done_x),
    .quot  (quot_x)
  );

  btr_div #(.NUM_W(NUM_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (dh),
    .done  (done_y),
    .quot  (quot_y)
  );

  // Split into index and fraction; saturate to the last texel past the edge.
  logic [IP_W-1:0]      ip_x, ip_y;
  logic                 sat_x, sat_y;
  logic [DIM_W-1:0]     swm1, shm1, x0p1, y0p1;
  logic [AW-1:0]        x0, y0, x1, y1;
  logic [FRAC_BITS-1:0] fx, fy;

  assign ip_x  = quot_x[NUM_W-1:FRAC_BITS];
  assign ip_y  = quot_y[NUM_W-1:FRAC_BITS];
  assign sat_x = ip_x >= IP_W'(sw);
  assign sat_y = ip_y >= IP_W'(sh);
  assign swm1  = DIM_W'(sw) - DIM_W'(1);
  assign shm1  = DIM_W'(sh) - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (state == ST_LOC) begin
      x0 <= sat_x ? swm1[AW-1:0] : ip_x[AW-1:0];
      y0 <= sat_y ? shm1[AW-1:0] : ip_y[AW-1:0];
      fx <= sat_x ? '0 : quot_x[FRAC_BITS-1:0];
      fy <= sat_y ? '0 : quot_y[FRAC_BITS-1:0];
    end
  end

  // Right and lower neighbours, clamped to the last column and row.
  assign x0p1 = DIM_W'(x0) + DIM_W'(1);
  assign y0p1 = DIM_W'(y0) + DIM_W'(1);
  assign x1   = (x0p1 < DIM_W'(sw)) ? x0p1[AW-1:0] : swm1[AW-1:0];
  assign y1   = (y0p1 < DIM_W'(sh)) ? y0p1[AW-1:0] : shm1[AW-1:0];

  // ---------------------------------------------------------------------
  // Texel memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] mem_q;
  logic [DIM_W-1:0]   wx_ext, wy_ext;
  logic               mem_we;
  logic [2*AW-1:0]    wr_addr, rd_addr;
  logic               rd_pend;
  logic [1:0]         rd_slot;
  logic [TEXEL_W-1:0] texel [4];

  assign wx_ext  = DIM_W'(coord_x);
  assign wy_ext  = DIM_W'(coord_y);
  assign mem_we  = in_xfer && action == ACT_WRITE && wx_ext < MAX_DIM_W && wy_ext < MAX_DIM_W;
  assign wr_addr = {wy_ext[AW-1:0], wx_ext[AW-1:0]};

  // Read order: top-left, top-right, bottom-left, bottom-right.
  always_comb begin
    case (rd_cnt)
      2'd0:    rd_addr = {y0, x0};
      2'd1:    rd_addr = {y0, x1};
      2'd2:    rd_addr = {y1, x0};
      default: rd_addr = {y1, x1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {red_in, green_in, blue_in};
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      if (state == ST_LOC) begin
        rd_cnt <= '0;
      end else if (mem_re) begin
        rd_cnt <= rd_cnt + 2'd1;
      end
    end
  end

  // Read data lands in mem_q in the cycle after issue; file it by slot.
  always_ff @(posedge clk) begin
    rd_slot <= rd_cnt;
    if (rd_pend) begin
      texel[rd_slot] <= mem_q;
    end
  end

  // ---------------------------------------------------------------------
  // Filter: lerp along x on both rows, then along y
  // ---------------------------------------------------------------------
  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic signed [CH_W+1:0] d;
    logic signed [PW-1:0]   p;
    logic signed [CH_W+1:0] q;
    logic signed [CH_W+1:0] s;
    d = $signed({2'b00, b}) - $signed({2'b00, a});
    p = PW'(d) * $signed({1'b0, f});
    q = (CH_W + 2)'(p >>> FRAC_BITS);
    s = $signed({2'b00, a}) + q;
    return s[CH_W-1:0];
  endfunction

  logic [TEXEL_W-1:0] top_row, bot_row, res;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (state == ST_LERP_A) begin
        top_row[CH_W*c +: CH_W] <= lerp(texel[0][CH_W*c +: CH_W],
                                        texel[1][CH_W*c +: CH_W], fx);
        bot_row[CH_W*c +: CH_W] <= lerp(texel[2][CH_W*c +: CH_W],
                                        texel[3][CH_W*c +: CH_W], fx);
      end
      if (state == ST_LERP_B) begin
        res[CH_W*c +: CH_W] <= lerp(top_row[CH_W*c +: CH_W],
                                    bot_row[CH_W*c +: CH_W], fy);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out   <= res[2*CH_W +: CH_W];
      green_out <= res[CH_W +: CH_W];
      blue_out  <= res[0 +: CH_W];
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Both dividers start together and run the same length.
  assert property (@(posedge clk) disable iff (rst) done_x == done_y)
    else $error("x and y dividers out of step");

  // Located texels always fall inside the source image.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> (DIM_W'(x0) < DIM_W'(sw)) && (DIM_W'(y0) < DIM_W'(sh)))
    else $error("texel index outside source size");

  // Memory writes only come from items taken while idle.
  assert property (@(posedge clk) disable iff (rst) mem_we |-> state == ST_IDLE)
    else $error("texel write while a sample is in progress");

  // A new result only appears from the final state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("output loaded outside the final state");

  // Four reads are issued per sample; the filter follows the last one, with the wait state between.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_LERP_A |-> $past(mem_re, 2) && !$past(mem_re))
    else $error("read sequence out of step with filter");

endmodule

/* rtl/core/btr_div.sv */
// Restoring divider, one quotient bit per cycle, for the source position.
// Depends on btr_pkg for the divisor width.
`timescale 1ns / 1ps

module btr_div import btr_pkg::*; #(
  parameter int NUM_W = PROD_W + FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [SIZE_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] den_q;
  logic [NUM_W-1:0]  work;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic              ge;
  logic [SIZE_W-1:0] rem_next;

  assign shifted  = {rem, work[NUM_W-1]};
  assign diff     = shifted - {1'b0, den_q};
  assign ge       = shifted >= {1'b0, den_q};
  assign rem_next = ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
  assign quot     = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      work  <= num;
      den_q <= den;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[NUM_W-2:0], ge};
    end
  end

endmodule
